/* rtl/core/pone_pkg.sv */
// Shared types and constants for the polygon orientation and edge normal block.
package pone_pkg;

    localparam int COORD_W       = 24;
    localparam int NORM_W        = 16;
    localparam int IDX_W         = 4;
    localparam int MAX_VERTS_DEF = 16;
    localparam int NORM_ONE      = 16384;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2
    } t_status;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W:0]   dx;
        logic signed [COORD_W:0]   dy;
    } t_norm_req;

    typedef struct packed {
        logic                      done;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
    } t_norm_rsp;

endpackage

/* rtl/core/polygon_orient_and_edge_normals_top.sv */
// Top level: vertex loading, shoelace sum, orientation fix and edge sequencing.
// Vertices are taken while busy is low. A stored vertex after the first keeps busy high
// while its cross product is formed and added in T_MUL and T_ACC; the first vertex and
// any vertex dropped because the store is full skip that step. On the last vertex the
// closing cross product is formed in T_FIN, T_CMUL and T_CACC and the orientation is
// decided in T_SETUP, then one result per vertex follows.
// Each result passes the store read in T_RD and T_WAIT, then the normal unit: normalising
// shifts, 32 square root steps, 15 divide steps and its set-up and hand-over states.
// A zero-length edge goes straight to the done state of the normal unit. An error
// result is registered in T_FIN, reached after T_MUL and T_ACC when the last vertex
// went through the cross product. Results appear on o_valid for one cycle each and
// are never held back.
module polygon_orient_and_edge_normals_top #(
    parameter int MAX_VERTS = pone_pkg::MAX_VERTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [pone_pkg::COORD_W-1:0]   i_vertex_x,
    input  logic signed [pone_pkg::COORD_W-1:0]   i_vertex_y,
    input  logic                                  i_final_vertex,
    output logic                                  o_valid,
    output logic [pone_pkg::IDX_W-1:0]            o_edge_index,
    output logic signed [pone_pkg::COORD_W-1:0]   o_out_x,
    output logic signed [pone_pkg::COORD_W-1:0]   o_out_y,
    output logic signed [pone_pkg::NORM_W-1:0]    o_normal_x,
    output logic signed [pone_pkg::NORM_W-1:0]    o_normal_y,
    output logic                                  o_was_reversed,
    output logic [1:0]                            o_status,
    output logic                                  o_final_result
);

    localparam int CW    = pone_pkg::COORD_W;
    localparam int AW    = $clog2(MAX_VERTS);
    localparam int CNT_W = $clog2(MAX_VERTS + 1);
    localparam int SUM_W = 2 * CW + 1 + CNT_W;

    typedef enum logic [9:0] {
        T_IDLE  = 10'b00_0000_0001,
        T_MUL   = 10'b00_0000_0010,
        T_ACC   = 10'b00_0000_0100,
        T_FIN   = 10'b00_0000_1000,
        T_CMUL  = 10'b00_0001_0000,
        T_CACC  = 10'b00_0010_0000,
        T_SETUP = 10'b00_0100_0000,
        T_RD    = 10'b00_1000_0000,
        T_WAIT  = 10'b01_0000_0000,
        T_NRM   = 10'b10_0000_0000
    } t_tstate;

    t_tstate                  r_state;
    logic [CNT_W-1:0]         r_cnt, r_i;
    logic                     r_ovf, r_fin, r_rev;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [CW-1:0]     r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic signed [CW-1:0]     r_opa_x, r_opa_y, r_opb_x, r_opb_y;
    logic signed [2*CW-1:0]   r_p1, r_p2;
    logic signed [CW-1:0]     r_ox, r_oy;
    logic                     r_valid;

    logic                     w_accept, w_stored, w_we;
    logic signed [2*CW:0]     w_diff;
    logic [CNT_W-1:0]         w_j, w_a, w_b, w_last;
    logic [CW-1:0]            w_ax, w_ay, w_bx, w_by;
    pone_pkg::t_norm_req      w_req;
    pone_pkg::t_norm_rsp      w_rsp;

    assign busy     = (r_state != T_IDLE);
    assign w_accept = start && !busy;
    assign w_stored = r_cnt < CNT_W'(MAX_VERTS);
    assign w_we     = w_accept && w_stored;
    assign w_diff   = (2*CW+1)'(r_p1) - (2*CW+1)'(r_p2);
    assign w_last   = r_cnt - CNT_W'(1);
    assign w_j      = (r_i == w_last) ? '0 : r_i + CNT_W'(1);
    assign w_a      = r_rev ? w_last - r_i : r_i;
    assign w_b      = r_rev ? w_last - w_j : w_j;

    pone_vstore #(
        .DEPTH (MAX_VERTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_cnt[AW-1:0]),
        .i_wx      (i_vertex_x),
        .i_wy      (i_vertex_y),
        .i_raddr_a (w_a[AW-1:0]),
        .i_raddr_b (w_b[AW-1:0]),
        .o_ax      (w_ax),
        .o_ay      (w_ay),
        .o_bx      (w_bx),
        .o_by      (w_by)
    );

    assign w_req.start = (r_state == T_WAIT);
    assign w_req.dx    = $signed({w_bx[CW-1], w_bx}) - $signed({w_ax[CW-1], w_ax});
    assign w_req.dy    = $signed({w_by[CW-1], w_by}) - $signed({w_ay[CW-1], w_ay});

    pone_normal u_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_p1 <= r_opa_x * r_opb_y;
        r_p2 <= r_opa_y * r_opb_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_fin <= i_final_vertex;
                        if (w_stored) begin
                            r_opa_x  <= r_prev_x;
                            r_opa_y  <= r_prev_y;
                            r_opb_x  <= i_vertex_x;
                            r_opb_y  <= i_vertex_y;
                            r_prev_x <= i_vertex_x;
                            r_prev_y <= i_vertex_y;
                            if (r_cnt == '0) begin
                                r_first_x <= i_vertex_x;
                                r_first_y <= i_vertex_y;
                            end
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (w_stored && (r_cnt != '0)) begin
                            r_state <= T_MUL;
                        end else if (i_final_vertex) begin
                            r_state <= T_FIN;
                        end
                    end
                end
                T_MUL: r_state <= T_ACC;
                T_ACC: begin
                    r_sum   <= r_sum + SUM_W'(w_diff);
                    r_state <= r_fin ? T_FIN : T_IDLE;
                end
                T_FIN: begin
                    if (r_ovf || (r_cnt < CNT_W'(3))) begin
                        r_valid        <= 1'b1;
                        o_edge_index   <= '0;
                        o_out_x        <= '0;
                        o_out_y        <= '0;
                        o_normal_x     <= '0;
                        o_normal_y     <= '0;
                        o_was_reversed <= 1'b0;
                        o_status       <= r_ovf ? pone_pkg::ST_MANY : pone_pkg::ST_FEW;
                        o_final_result <= 1'b1;
                        r_cnt          <= '0;
                        r_sum          <= '0;
                        r_ovf          <= 1'b0;
                        r_state        <= T_IDLE;
                    end else begin
                        r_opa_x <= r_prev_x;
                        r_opa_y <= r_prev_y;
                        r_opb_x <= r_first_x;
                        r_opb_y <= r_first_y;
                        r_state <= T_CMUL;
                    end
                end
                T_CMUL: r_state <= T_CACC;
                T_CACC: begin
                    r_sum   <= r_sum + SUM_W'(w_diff);
                    r_state <= T_SETUP;
                end
                T_SETUP: begin
                    r_rev   <= r_sum[SUM_W-1];
                    r_i     <= '0;
                    r_state <= T_RD;
                end
                T_RD: r_state <= T_WAIT;
                T_WAIT: begin
                    r_ox    <= w_ax;
                    r_oy    <= w_ay;
                    r_state <= T_NRM;
                end
                T_NRM: begin
                    if (w_rsp.done) begin
                        r_valid        <= 1'b1;
                        o_edge_index   <= pone_pkg::IDX_W'(r_i);
                        o_out_x        <= r_ox;
                        o_out_y        <= r_oy;
                        o_normal_x     <= w_rsp.nx;
                        o_normal_y     <= w_rsp.ny;
                        o_was_reversed <= r_rev;
                        o_status       <= pone_pkg::ST_OK;
                        o_final_result <= (r_i == w_last);
                        if (r_i == w_last) begin
                            r_cnt   <= '0;
                            r_sum   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= T_IDLE;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= T_RD;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;

endmodule

/* rtl/core/pone_vstore.sv */
// Vertex store: one write port, two registered read ports.
module pone_vstore #(
    parameter int DEPTH = pone_pkg::MAX_VERTS_DEF,
    parameter int AW    = $clog2(pone_pkg::MAX_VERTS_DEF)
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [AW-1:0]                   i_waddr,
    input  logic [pone_pkg::COORD_W-1:0]    i_wx,
    input  logic [pone_pkg::COORD_W-1:0]    i_wy,
    input  logic [AW-1:0]                   i_raddr_a,
    input  logic [AW-1:0]                   i_raddr_b,
    output logic [pone_pkg::COORD_W-1:0]    o_ax,
    output logic [pone_pkg::COORD_W-1:0]    o_ay,
    output logic [pone_pkg::COORD_W-1:0]    o_bx,
    output logic [pone_pkg::COORD_W-1:0]    o_by
);

    logic [2*pone_pkg::COORD_W-1:0] r_mem [DEPTH];
    logic [2*pone_pkg::COORD_W-1:0] r_rda;
    logic [2*pone_pkg::COORD_W-1:0] r_rdb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wx, i_wy};
        end
        r_rda <= r_mem[i_raddr_a];
        r_rdb <= r_mem[i_raddr_b];
    end

    assign o_ax = r_rda[2*pone_pkg::COORD_W-1:pone_pkg::COORD_W];
    assign o_ay = r_rda[pone_pkg::COORD_W-1:0];
    assign o_bx = r_rdb[2*pone_pkg::COORD_W-1:pone_pkg::COORD_W];
    assign o_by = r_rdb[pone_pkg::COORD_W-1:0];

endmodule

/* rtl/core/pone_normal.sv */
// Iterative unit normal: normalise, square, bitwise square root, two restoring divides.
module pone_normal (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pone_pkg::t_norm_req   i_req,
    output pone_pkg::t_norm_rsp   o_rsp
);

    localparam int M_W  = pone_pkg::COORD_W;
    localparam int SQ_W = 2 * M_W;
    localparam int V_W  = SQ_W + 1 + 14;
    localparam int L_W  = 32;
    localparam int R_W  = 48;
    localparam int Q_W  = 15;

    typedef enum logic [7:0] {
        N_IDLE = 8'b0000_0001,
        N_NORM = 8'b0000_0010,
        N_SQR  = 8'b0000_0100,
        N_SUM  = 8'b0000_1000,
        N_SQRT = 8'b0001_0000,
        N_PREP = 8'b0010_0000,
        N_DIV  = 8'b0100_0000,
        N_DONE = 8'b1000_0000
    } t_nstate;

    t_nstate          r_state;
    logic [M_W-1:0]   r_ax, r_ay;
    logic             r_negdy, r_posdx, r_zero;
    logic [SQ_W-1:0]  r_sqx, r_sqy;
    logic [V_W-1:0]   r_v, r_root, r_bit;
    logic [R_W-1:0]   r_remx, r_remy, r_dsh;
    logic [Q_W-1:0]   r_qx, r_qy;
    logic [3:0]       r_cnt;

    logic [M_W:0]     w_absdx, w_absdy;
    logic [SQ_W-1:0]  w_sqx, w_sqy;
    logic [V_W:0]     w_trial;
    logic [L_W-1:0]   w_lenq;
    logic             w_gex, w_gey;
    logic [Q_W-1:0]   w_capx, w_capy;

    assign w_absdx = i_req.dx[M_W] ? (M_W+1)'(-i_req.dx) : (M_W+1)'(i_req.dx);
    assign w_absdy = i_req.dy[M_W] ? (M_W+1)'(-i_req.dy) : (M_W+1)'(i_req.dy);
    assign w_sqx   = r_ax * r_ax;
    assign w_sqy   = r_ay * r_ay;
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign w_lenq  = r_root[L_W-1:0];
    assign w_gex   = r_remx >= r_dsh;
    assign w_gey   = r_remy >= r_dsh;
    assign w_capx  = (r_qx > Q_W'(pone_pkg::NORM_ONE)) ? Q_W'(pone_pkg::NORM_ONE) : r_qx;
    assign w_capy  = (r_qy > Q_W'(pone_pkg::NORM_ONE)) ? Q_W'(pone_pkg::NORM_ONE) : r_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_req.start) begin
                        r_ax    <= w_absdx[M_W-1:0];
                        r_ay    <= w_absdy[M_W-1:0];
                        r_negdy <= i_req.dy[M_W];
                        r_posdx <= !i_req.dx[M_W] && (i_req.dx != '0);
                        r_zero  <= (i_req.dx == '0) && (i_req.dy == '0);
                        r_state <= ((i_req.dx == '0) && (i_req.dy == '0)) ? N_DONE : N_NORM;
                    end
                end
                N_NORM: begin
                    if (r_ax[M_W-1] || r_ay[M_W-1]) begin
                        r_state <= N_SQR;
                    end else begin
                        r_ax <= {r_ax[M_W-2:0], 1'b0};
                        r_ay <= {r_ay[M_W-2:0], 1'b0};
                    end
                end
                N_SQR: begin
                    r_sqx   <= w_sqx;
                    r_sqy   <= w_sqy;
                    r_state <= N_SUM;
                end
                N_SUM: begin
                    r_v     <= {(SQ_W+1)'(r_sqx) + (SQ_W+1)'(r_sqy), 14'd0};
                    r_root  <= '0;
                    r_bit   <= {1'b1, (V_W-1)'(0)};
                    r_state <= N_SQRT;
                end
                N_SQRT: begin
                    if ({1'b0, r_v} >= w_trial) begin
                        r_v    <= r_v - w_trial[V_W-1:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= N_PREP;
                    end
                end
                N_PREP: begin
                    r_remx  <= (R_W'(r_ay) << 22) + R_W'(w_lenq);
                    r_remy  <= (R_W'(r_ax) << 22) + R_W'(w_lenq);
                    r_dsh   <= R_W'({w_lenq, 1'b0}) << 14;
                    r_qx    <= '0;
                    r_qy    <= '0;
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (w_gex) begin
                        r_remx <= r_remx - r_dsh;
                    end
                    if (w_gey) begin
                        r_remy <= r_remy - r_dsh;
                    end
                    r_qx  <= {r_qx[Q_W-2:0], w_gex};
                    r_qy  <= {r_qy[Q_W-2:0], w_gey};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(Q_W - 1)) begin
                        r_state <= N_DONE;
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    always_comb begin
        o_rsp.done = (r_state == N_DONE);
        if (r_zero) begin
            o_rsp.nx = '0;
            o_rsp.ny = '0;
        end else begin
            o_rsp.nx = r_negdy ? -pone_pkg::NORM_W'(w_capx) : pone_pkg::NORM_W'(w_capx);
            o_rsp.ny = r_posdx ? -pone_pkg::NORM_W'(w_capy) : pone_pkg::NORM_W'(w_capy);
        end
    end

endmodule

/* rtl/core/pone_checker.sv */
// Port-level checker for the polygon orientation block, bound to the top level.
module pone_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 i_final_vertex,
    input logic                                 o_valid,
    input logic [1:0]                           o_status,
    input logic                                 o_final_result,
    input logic signed [pone_pkg::NORM_W-1:0]   o_normal_x
);

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_result |=> busy)
        else $error("run ended early");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_final_result |=> !o_valid)
        else $error("result straight after last result");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != pone_pkg::ST_OK) |-> o_final_result && (o_normal_x == '0))
        else $error("error item malformed");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_final_vertex |=> !o_valid)
        else $error("result after a non-final vertex");

endmodule

bind polygon_orient_and_edge_normals_top pone_checker u_pone_checker (.*);
